>>> hdl/brq_pkg.sv
// Shared constants, codes and interface types of the byte ring queue.
`default_nettype none
package brq_pkg;

    localparam int DEPTH     = 256;
    localparam int MAX_BURST = 64;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = 9;
    localparam int OP_W   = 3;
    localparam int CNT_W  = 7;
    localparam int OFF_W  = 8;
    localparam int ST_W   = 3;

    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP   = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd3;
    localparam logic [OP_W-1:0] OP_DROP  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_SHORT    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [7:0]       data_in;
        logic [CNT_W-1:0] count;
        logic [OFF_W-1:0] offset;
        logic             burst_first;
    } in_item_t;

    typedef struct packed {
        logic accept;   // take the input item this cycle
        logic step;     // emit the next byte of a pop or peek
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;     // output register can be loaded
        logic stream_start; // presented item starts a byte-by-byte read
        logic last_byte;    // current read step is the final one
    } dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/byte_ring_queue_with_peek.sv
// Top level of the byte ring queue with peek: port packing, controller and datapath.
// A result is registered on acceptance; a pop or peek's first byte is loaded at the first read step after it.
// Push, clear, drop and failed reads take a new item whenever the output register is free; pop and peek
//   are accepted, then emit their bytes one read step at a time, set by the single store read port.
// A read run blocks new items until its last byte is loaded into the output register.
// Reset (aresetn low at a clock edge): queue empty, ring size 256, no result pending;
//   the byte store itself is not cleared.
`default_nettype none
module byte_ring_queue_with_peek (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // data_in[7:0], count[14:8], offset[22:15], pad
    input  wire logic [3:0]  s_tuser,  // operation[2:0], burst_first[3]
    // ring size register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data, // queue_size
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // data_out[7:0], status[10:8], done_count[17:11],
                                       // fill_level[26:18], pad
    output logic [0:0]       m_tuser,  // has_data[0]
    output logic             m_tlast
);
    import brq_pkg::*;

    in_item_t          item;
    ctrl_cmd_t         cmd;
    dp_stat_t          stat;
    logic [7:0]        data_out;
    logic              has_data;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  done_count;
    logic [FILL_W-1:0] fill_level;

    assign item.operation   = s_tuser[2:0];
    assign item.burst_first = s_tuser[3];
    assign item.data_in     = s_tdata[7:0];
    assign item.count       = s_tdata[14:8];
    assign item.offset      = s_tdata[22:15];

    // size writes must only come while idle, which the block does not enforce; the port never stalls
    assign cfg_ready = 1'b1;

    brq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brq_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .m_tready     (m_tready),
        .m_valid      (m_tvalid),
        .m_data_out   (data_out),
        .m_has_data   (has_data),
        .m_status     (status),
        .m_done_count (done_count),
        .m_fill_level (fill_level),
        .m_last       (m_tlast)
    );

    assign m_tdata = {5'b00000, fill_level, done_count, status, data_out};
    assign m_tuser = has_data;

endmodule
`default_nettype wire

>>> hdl/brq_ctrl.sv
// Controller: sequences item acceptance and byte-by-byte read-out.
`default_nettype none
module brq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire brq_pkg::dp_stat_t stat,
    output brq_pkg::ctrl_cmd_t     cmd
);
    import brq_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_STREAM = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready   = (state_reg == S_IDLE) && stat.out_free;
    assign cmd.accept = s_tvalid && s_tready;
    assign cmd.step   = (state_reg == S_STREAM) && stat.out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept && stat.stream_start) state_next = S_STREAM;
            end
            S_STREAM: begin
                if (cmd.step && stat.last_byte) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/brq_datapath.sv
// Datapath: byte store, ring pointers, fill count and the output register.
`default_nettype none
module brq_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire brq_pkg::in_item_t             item,
    input  wire brq_pkg::ctrl_cmd_t            cmd,
    output brq_pkg::dp_stat_t                  stat,
    input  wire logic                          cfg_valid,
    input  wire logic [brq_pkg::FILL_W-1:0]    cfg_data,
    input  wire logic                          m_tready,
    output logic                               m_valid,
    output logic [7:0]                         m_data_out,
    output logic                               m_has_data,
    output logic [brq_pkg::ST_W-1:0]           m_status,
    output logic [brq_pkg::CNT_W-1:0]          m_done_count,
    output logic [brq_pkg::FILL_W-1:0]         m_fill_level,
    output logic                               m_last
);
    import brq_pkg::*;

    localparam logic [FILL_W-1:0] DEPTH_F   = FILL_W'(DEPTH);
    localparam logic [CNT_W-1:0]  MAXB_C    = CNT_W'(MAX_BURST);
    localparam logic [FILL_W-1:0] ONE_F     = FILL_W'(1);
    localparam logic [FILL_W-1:0] TWO_F     = FILL_W'(2);

    // index + step, wrapped once by the ring size
    function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                             input logic [FILL_W-1:0] by,
                                             input logic [FILL_W-1:0] q);
        logic [FILL_W:0] s;
        s = {{(FILL_W+1-IDX_W){1'b0}}, idx} + {1'b0, by};
        if (s >= {1'b0, q}) s = s - {1'b0, q};
        return s[IDX_W-1:0];
    endfunction

    logic [7:0] mem [DEPTH];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              refused_reg, refused_next;
    logic [FILL_W-1:0] qsize_reg, qsize_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              pop_mode_reg, pop_mode_next;

    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_has_reg;
    logic [ST_W-1:0]   out_status_reg;
    logic [CNT_W-1:0]  out_done_reg;
    logic [FILL_W-1:0] out_fill_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]  cnt_sat;
    logic [CNT_W-1:0]  pop_n;
    logic [FILL_W-1:0] drop_n;
    logic [FILL_W-1:0] free_slots;
    logic [FILL_W:0]   peek_end;
    logic              peek_ok;
    logic              full;
    logic              wr_en;
    logic [ST_W-1:0]   res_status;
    logic [CNT_W-1:0]  res_done;
    logic [IDX_W-1:0]  rd_adv;

    assign cnt_sat    = (item.count > MAXB_C) ? MAXB_C : item.count;
    assign pop_n      = ({2'b00, cnt_sat} > fill_reg) ? fill_reg[CNT_W-1:0] : cnt_sat;
    assign drop_n     = ({2'b00, item.count} > fill_reg) ? fill_reg : {2'b00, item.count};
    assign free_slots = qsize_reg - fill_reg;
    assign peek_end   = {2'b00, item.offset} + {3'b000, cnt_sat};
    assign peek_ok    = (fill_reg != '0) && !(peek_end > {1'b0, fill_reg})
                        && (cnt_sat != '0);
    assign full       = (fill_reg >= qsize_reg);
    assign rd_adv     = adv(rd_idx_reg, ONE_F, qsize_reg);

    assign stat.out_free     = !out_valid_reg || m_tready;
    assign stat.stream_start = ((item.operation == OP_POP) && (pop_n != '0))
                               || ((item.operation == OP_PEEK) && peek_ok);
    assign stat.last_byte    = (remain_reg == CNT_W'(1));

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        refused_next  = refused_reg;
        qsize_next    = qsize_reg;
        rd_idx_next   = rd_idx_reg;
        remain_next   = remain_reg;
        total_next    = total_reg;
        pop_mode_next = pop_mode_reg;
        wr_en         = 1'b0;
        res_status    = ST_OK;
        res_done      = '0;

        if (cmd.step) begin
            rd_idx_next = rd_adv;
            remain_next = remain_reg - CNT_W'(1);
            if (pop_mode_reg) begin
                head_next = rd_adv;
                fill_next = fill_reg - ONE_F;
            end
        end else if (cmd.accept) begin
            case (item.operation)
                OP_CLEAR: begin
                    head_next    = '0;
                    tail_next    = '0;
                    fill_next    = '0;
                    refused_next = 1'b0;
                end
                OP_PUSH: begin
                    if (item.burst_first) begin
                        if (full) begin
                            res_status   = ST_FULL;
                            refused_next = 1'b1;
                        end else if ((item.count > MAXB_C)
                                     || ({2'b00, item.count} > free_slots)) begin
                            res_status   = ST_NOSPACE;
                            refused_next = 1'b1;
                        end else if (item.count == '0) begin
                            refused_next = 1'b1;
                        end else begin
                            refused_next = 1'b0;
                            wr_en        = 1'b1;
                        end
                    end else if (refused_reg) begin
                        res_status = full ? ST_FULL : ST_NOSPACE;
                    end else if (full) begin
                        res_status   = ST_FULL;
                        refused_next = 1'b1;
                    end else begin
                        wr_en = 1'b1;
                    end
                    if (wr_en) begin
                        tail_next = adv(tail_reg, ONE_F, qsize_reg);
                        fill_next = fill_reg + ONE_F;
                    end
                end
                OP_POP: begin
                    rd_idx_next   = head_reg;
                    remain_next   = pop_n;
                    total_next    = pop_n;
                    pop_mode_next = 1'b1;
                end
                OP_PEEK: begin
                    if (fill_reg == '0)                        res_status = ST_EMPTY;
                    else if (peek_end > {1'b0, fill_reg})      res_status = ST_SHORT;
                    rd_idx_next   = adv(head_reg, {1'b0, item.offset}, qsize_reg);
                    remain_next   = cnt_sat;
                    total_next    = cnt_sat;
                    pop_mode_next = 1'b0;
                end
                OP_DROP: begin
                    head_next = adv(head_reg, drop_n, qsize_reg);
                    fill_next = fill_reg - drop_n;
                    res_done  = drop_n[CNT_W-1:0];
                end
                default: ;
            endcase
        end

        // size write empties the queue; it must only arrive while idle, which the block does not enforce
        if (cfg_valid) begin
            if (cfg_data < TWO_F)         qsize_next = TWO_F;
            else if (cfg_data > DEPTH_F)  qsize_next = DEPTH_F;
            else                          qsize_next = cfg_data;
            head_next    = '0;
            tail_next    = '0;
            fill_next    = '0;
            refused_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            refused_reg   <= 1'b0;
            qsize_reg     <= DEPTH_F;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            refused_reg <= refused_next;
            qsize_reg   <= qsize_next;
            remain_reg  <= remain_next;
            if (cmd.step || (cmd.accept && !stat.stream_start)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload side: no reset
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        total_reg    <= total_next;
        pop_mode_reg <= pop_mode_next;
        if (cmd.step) begin
            out_has_reg    <= 1'b1;
            out_status_reg <= ST_OK;
            out_done_reg   <= stat.last_byte ? total_reg : '0;
            out_fill_reg   <= fill_next;
            out_last_reg   <= stat.last_byte;
        end else if (cmd.accept && !stat.stream_start) begin
            out_has_reg    <= 1'b0;
            out_status_reg <= res_status;
            out_done_reg   <= res_done;
            out_fill_reg   <= fill_next;
            out_last_reg   <= 1'b1;
        end
    end

    // byte store, registered read straight into the output data
    always_ff @(posedge aclk) begin
        if (wr_en) mem[tail_reg] <= item.data_in;
        if (cmd.step) begin
            out_data_reg <= mem[rd_idx_reg];
        end else if (cmd.accept) begin
            out_data_reg <= '0;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_data_out   = out_data_reg;
    assign m_has_data   = out_has_reg;
    assign m_status     = out_status_reg;
    assign m_done_count = out_done_reg;
    assign m_fill_level = out_fill_reg;
    assign m_last       = out_last_reg;

    a_no_accept_in_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.accept && cmd.step))
        else $error("accept and read step together");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= qsize_reg)
        else $error("fill count above ring size");

    a_pop_step_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && pop_mode_reg && !cfg_valid) |=> (fill_reg == $past(fill_reg) - ONE_F))
        else $error("pop step did not remove one byte");

    a_last_step_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && stat.last_byte) |=> (remain_reg == '0))
        else $error("read run not finished after last byte");

endmodule
`default_nettype wire
